@@ hdl/ucb_pkg.sv @@
// Shared constants and status type for the UCB arm selector.
package ucb_pkg;

  localparam int Q_W       = 24;     // value estimate, signed Q8.16
  localparam int REWARD_W  = 16;     // reward, signed Q8.8
  localparam int WEIGHT_W  = 16;     // exploration weight, Q4.12
  localparam int ARMSREG_W = 5;
  localparam int WEIGHT_FRAC = 12;
  localparam int FRAC_BITS = 16;     // log2 fraction bits
  localparam int MUL_W     = 32;
  localparam logic [15:0] LN2_Q16 = 16'd45426;
  localparam logic [15:0] WEIGHT_RESET = 16'd8192;
  localparam logic [4:0]  ARMS_RESET   = 5'd10;
  localparam logic REG_WEIGHT = 1'b0;
  localparam logic REG_ARMS   = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } ucb_stat_t;

endpackage

@@ hdl/ucb_bandit_arm_selector.sv @@
// UCB1 arm selector: sequencer, shared multiplier, divider and root units.
//
//  channel | dir | transfer carries
//  s_*     | in  | tdata: reward[15:0]; tuser: new_run
//  m_*     | out | tdata: chosen_arm[3:0], zero pad; tuser: untried_pick
//  apb     | in  | 0x0 exploration_weight, 0x4 arms_in_use
//
// A reward updates the arm's mean (serial divide), scans the arms for an
// untried one and, if all are tried, normalizes the step count, builds the
// log by repeated squaring and a multiply by ln 2, then scores each arm (37-bit
// serial divide plus 19-bit root).
// s_tready is high only while the sequencer idles; a result held on m_* does
// not block the next input. Reset is synchronous and clears all valid bits.
module ucb_bandit_arm_selector #(
  parameter int MAX_ARMS    = 16,
  parameter int COUNT_WIDTH = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // reward[15:0]
  input  logic        s_tuser,   // new_run
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // chosen_arm[3:0], zeros[7:4]
  output logic        m_tuser,   // untried_pick
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ucb_pkg::*;

  localparam int AW     = (MAX_ARMS > 1) ? $clog2(MAX_ARMS) : 1;
  localparam int CW     = COUNT_WIDTH;
  localparam int XW     = CW + 1;
  localparam int NW     = XW + 31;
  localparam int PW     = $clog2(XW);
  localparam int LG_W   = PW + FRAC_BITS;
  localparam int DVD_W  = LG_W + 16;
  localparam int RT_W   = (DVD_W + 1) / 2;
  localparam int BON_W  = WEIGHT_W + RT_W - WEIGHT_FRAC;
  localparam int SC_W   = ((BON_W > Q_W) ? BON_W : Q_W) + 2;
  localparam int RND_W  = $clog2(FRAC_BITS);
  localparam logic [CW-1:0] CNT_MAX = '1;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_MDAT = 14'b00000000000010,
    S_MDIV = 14'b00000000000100,
    S_SRD  = 14'b00000000001000,
    S_SCHK = 14'b00000000010000,
    S_NORM = 14'b00000000100000,
    S_SQ   = 14'b00000001000000,
    S_LN   = 14'b00000010000000,
    S_ARD  = 14'b00000100000000,
    S_ADAT = 14'b00001000000000,
    S_ADIV = 14'b00010000000000,
    S_ASQ  = 14'b00100000000000,
    S_ABON = 14'b01000000000000,
    S_OUT  = 14'b10000000000000
  } state_t;

  state_t state;

  logic [WEIGHT_W-1:0]  weight;
  logic [ARMSREG_W-1:0] arms;
  logic [AW:0]          k;

  logic [MAX_ARMS-1:0]  valid;
  logic                 vld_rd;
  logic [AW:0]          i;
  logic [AW:0]          i_inc;
  logic [AW-1:0]        arm;
  logic                 untried;
  logic [AW-1:0]        last_arm;
  logic [CW-1:0]        steps;
  logic signed [Q_W:0]  rwd;
  logic signed [Q_W-1:0] q_r;
  logic [CW-1:0]        cnt_r;
  logic                 neg;
  logic [NW-1:0]        norm;
  logic [PW-1:0]        p;
  logic [MUL_W-1:0]     m;
  logic [FRAC_BITS-1:0] frac;
  logic [RND_W-1:0]     rnd;
  logic [LG_W-1:0]      ln;
  logic signed [SC_W-1:0] best;
  logic [3:0]           out_arm;
  logic                 out_untried;

  // RAM: {estimate, count}
  logic                 ram_we;
  logic [AW-1:0]        ram_raddr;
  logic [Q_W+CW-1:0]    ram_wdata;
  logic [Q_W+CW-1:0]    ram_rdata;
  logic signed [Q_W-1:0] rd_q;
  logic [CW-1:0]        rd_cnt;

  // shared multiplier
  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic [2*MUL_W-1:0]   prod;

  logic                 div_start;
  logic [DVD_W-1:0]     div_dvd;
  logic [CW-1:0]        div_dvs;
  logic [DVD_W-1:0]     div_quo;
  ucb_stat_t            div_stat;
  logic                 sq_start;
  logic [RT_W-1:0]      sq_root;
  ucb_stat_t            sq_stat;

  logic signed [Q_W:0]  q_ext;
  logic [CW-1:0]        n_sat;
  logic signed [Q_W:0]  diff;
  logic [Q_W:0]         mag;
  logic [Q_W:0]         quo;
  logic [Q_W:0]         q_new;
  logic [MUL_W:0]       sqv;
  logic [BON_W-1:0]     bonus;
  logic signed [SC_W-1:0] score;
  logic [31:0]          arm_ext;

  assign pready   = 1'b1;
  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {4'b0000, out_arm};
  assign m_tuser  = out_untried;
  assign i_inc    = i + 1'b1;
  assign arm_ext  = 32'(arm);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= WEIGHT_RESET;
      arms   <= ARMS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_WEIGHT: weight <= pwdata[WEIGHT_W-1:0];
        default:    arms   <= pwdata[ARMSREG_W-1:0];
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WEIGHT: prdata = 32'(weight);
      default:    prdata = 32'(arms);
    endcase
  end

  always_comb begin
    if (arms == '0) begin
      k = (AW+1)'(1);
    end else if (32'(arms) > MAX_ARMS) begin
      k = (AW+1)'(MAX_ARMS);
    end else begin
      k = (AW+1)'(arms);
    end
  end

  ucb_ram #(.WIDTH(Q_W + CW), .DEPTH(MAX_ARMS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (last_arm),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ucb_div #(.DW(DVD_W), .CW(CW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  ucb_isqrt #(.OW(RT_W)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value ((2*RT_W)'(div_quo)),
    .root  (sq_root),
    .stat  (sq_stat)
  );

  assign rd_q   = ram_rdata[Q_W+CW-1 -: Q_W];
  assign rd_cnt = ram_rdata[CW-1:0];

  always_comb begin
    q_ext = vld_rd ? (Q_W+1)'(rd_q) : '0;
    if (!vld_rd) begin
      n_sat = CW'(1);
    end else if (rd_cnt == CNT_MAX) begin
      n_sat = rd_cnt;
    end else begin
      n_sat = rd_cnt + 1'b1;
    end
    diff = rwd - q_ext;
    mag  = diff[Q_W] ? (Q_W+1)'(-diff) : diff;
    quo  = div_quo[Q_W:0];
    q_new = neg ? ((Q_W+1)'(q_r) - quo) : ((Q_W+1)'(q_r) + quo);
  end

  always_comb begin
    ram_raddr = i[AW-1:0];
    if (state == S_IDLE) begin
      ram_raddr = last_arm;
    end
    ram_we    = (state == S_MDIV) && div_stat.done;
    ram_wdata = {q_new[Q_W-1:0], cnt_r};
    div_start = 1'b0;
    div_dvd   = DVD_W'(mag);
    div_dvs   = n_sat;
    if (state == S_MDAT) begin
      div_start = 1'b1;
    end else if (state == S_ADAT) begin
      div_start = 1'b1;
      div_dvd   = {ln, 16'h0000};
      div_dvs   = rd_cnt;
    end
    sq_start = (state == S_ADIV) && div_stat.done;
  end

  always_comb begin
    mul_a = m;
    mul_b = m;
    unique case (state)
      S_LN: begin
        mul_a = MUL_W'({p, frac});
        mul_b = MUL_W'(LN2_Q16);
      end
      S_ABON: begin
        mul_a = MUL_W'(weight);
        mul_b = MUL_W'(sq_root);
      end
      default: begin
        mul_a = m;
        mul_b = m;
      end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign sqv   = prod[2*MUL_W-1 -: MUL_W+1];
  assign bonus = prod[WEIGHT_FRAC +: BON_W];
  assign score = SC_W'(q_r) + $signed(SC_W'(bonus));

  always_ff @(posedge clk) begin
    vld_rd <= valid[ram_raddr];
    if (rst) begin
      state       <= S_IDLE;
      valid       <= '0;
      steps       <= '0;
      last_arm    <= '0;
      m_tvalid    <= 1'b0;
      i           <= '0;
      arm         <= '0;
      untried     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser) begin
              valid    <= '0;
              steps    <= '0;
              last_arm <= '0;
              arm      <= '0;
              untried  <= 1'b1;
              state    <= S_OUT;
            end else begin
              rwd   <= $signed({s_tdata[15], s_tdata, 8'h00});
              state <= S_MDAT;
            end
          end
        end
        S_MDAT: begin
          q_r   <= q_ext[Q_W-1:0];
          cnt_r <= n_sat;
          neg   <= diff[Q_W];
          state <= S_MDIV;
        end
        S_MDIV: begin
          if (div_stat.done) begin
            valid[last_arm] <= 1'b1;
            if (steps != CNT_MAX) begin
              steps <= steps + 1'b1;
            end
            i     <= '0;
            state <= S_SRD;
          end
        end
        S_SRD: begin
          state <= S_SCHK;
        end
        S_SCHK: begin
          if (!vld_rd) begin
            arm     <= i[AW-1:0];
            untried <= 1'b1;
            state   <= S_OUT;
          end else if (i_inc == k) begin
            norm  <= (NW'(steps) + NW'(1)) << 31;
            p     <= PW'(XW - 1);
            state <= S_NORM;
          end else begin
            i     <= i_inc;
            state <= S_SRD;
          end
        end
        S_NORM: begin
          if (norm[NW-1]) begin
            m     <= norm[NW-1 -: MUL_W];
            rnd   <= '0;
            frac  <= '0;
            state <= S_SQ;
          end else begin
            norm <= {norm[NW-2:0], 1'b0};
            p    <= p - 1'b1;
          end
        end
        S_SQ: begin
          // m stays in [1,2) as Q1.31; overflow past 2 yields a fraction bit
          if (sqv[MUL_W]) begin
            m    <= sqv[MUL_W:1];
            frac <= {frac[FRAC_BITS-2:0], 1'b1};
          end else begin
            m    <= sqv[MUL_W-1:0];
            frac <= {frac[FRAC_BITS-2:0], 1'b0};
          end
          rnd <= rnd + 1'b1;
          if (rnd == RND_W'(FRAC_BITS - 1)) begin
            state <= S_LN;
          end
        end
        S_LN: begin
          ln    <= prod[16 +: LG_W];
          i     <= '0;
          state <= S_ARD;
        end
        S_ARD: begin
          state <= S_ADAT;
        end
        S_ADAT: begin
          q_r   <= rd_q;
          state <= S_ADIV;
        end
        S_ADIV: begin
          if (div_stat.done) begin
            state <= S_ASQ;
          end
        end
        S_ASQ: begin
          if (sq_stat.done) begin
            state <= S_ABON;
          end
        end
        S_ABON: begin
          untried <= 1'b0;
          if ((i == '0) || (score > best)) begin
            best <= score;
            arm  <= i[AW-1:0];
          end
          if (i_inc == k) begin
            state <= S_OUT;
          end else begin
            i     <= i_inc;
            state <= S_ARD;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid    <= 1'b1;
            out_arm     <= arm_ext[3:0];
            out_untried <= untried;
            last_arm    <= arm;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_new_run_clears: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> (steps == '0) && (valid == '0))
    else $error("new run did not clear state");

  a_div_done_ctx: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_MDIV) || (state == S_ADIV))
    else $error("divider finished outside a divide wait");

  a_sqrt_done_ctx: assert property (@(posedge clk) disable iff (rst)
    sq_stat.done |-> (state == S_ASQ))
    else $error("root unit finished outside its wait");

  a_score_pick_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) && !untried |-> ((AW+1)'(arm) < k))
    else $error("score pick outside the arms in use");
endmodule

@@ hdl/ucb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ucb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/ucb_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module ucb_div #(
  parameter int DW = 38,
  parameter int CW = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DW-1:0]      dividend,
  input  logic [CW-1:0]      divisor,
  output logic [DW-1:0]      quotient,
  output ucb_pkg::ucb_stat_t stat
);
  import ucb_pkg::*;

  logic [CW-1:0]         rem;
  logic [CW-1:0]         dvs;
  logic [$clog2(DW+1)-1:0] cnt;
  logic [CW:0]           trial;
  logic                  fits;

  assign trial = {rem, quotient[DW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
        rem       <= '0;
        dvs       <= divisor;
        quotient  <= dividend;
      end else if (stat.busy) begin
        if (fits) begin
          rem <= CW'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[CW-1:0];
        end
        quotient <= {quotient[DW-2:0], fits};
        cnt      <= cnt + 1'b1;
        if (cnt == ($clog2(DW+1))'(DW - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ hdl/ucb_isqrt.sv @@
// Digit-by-digit floor square root, one result bit per cycle.
module ucb_isqrt #(
  parameter int OW = 19
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2*OW-1:0]    value,
  output logic [OW-1:0]      root,
  output ucb_pkg::ucb_stat_t stat
);
  import ucb_pkg::*;

  logic [2*OW-1:0]         src;
  logic [OW:0]             rem;
  logic [$clog2(OW+1)-1:0] cnt;
  logic [OW+2:0]           shifted;
  logic [OW+2:0]           trial;
  logic                    fits;

  assign shifted = {rem, src[2*OW-1 -: 2]};
  assign trial   = {1'b0, root, 2'b01};
  assign fits    = shifted >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
        rem       <= '0;
        root      <= '0;
        src       <= value;
      end else if (stat.busy) begin
        if (fits) begin
          rem <= (OW+1)'(shifted - trial);
        end else begin
          rem <= shifted[OW:0];
        end
        root <= {root[OW-2:0], fits};
        src  <= {src[2*OW-3:0], 2'b00};
        cnt  <= cnt + 1'b1;
        if (cnt == ($clog2(OW+1))'(OW - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end
endmodule
